FILE: rtl/tbdsdp_pkg.sv
`default_nettype none

package tbdsdp_pkg;

  localparam int CODES      = 4;
  localparam int CODE_W     = 2;
  localparam int BYTE_W     = CODES * CODE_W;
  localparam int SCALE_W    = 16;
  localparam int WEIGHT_W   = SCALE_W + 1;
  localparam int ROW_W      = 16;
  localparam int GLEN_W     = 13;
  localparam int ROWS_W     = 17;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [GLEN_W-1:0] GLEN_RESET = 13'd128;
  localparam logic [GLEN_W-1:0] GLEN_MIN   = 13'd4;
  localparam logic [GLEN_W-1:0] GLEN_MAX   = 13'd4096;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 17'd4096;
  localparam logic [ROWS_W-1:0] ROWS_MAX   = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUP_LENGTH = 1'b0,
    REG_ROWS_IN_USE  = 1'b1
  } reg_e;

  typedef enum logic [CODE_W-1:0] {
    CODE_NEG_OUTER = 2'd0,
    CODE_NEG_INNER = 2'd1,
    CODE_POS_INNER = 2'd2,
    CODE_POS_OUTER = 2'd3
  } code_e;

  typedef struct packed {
    logic             row_end;
    logic [ROW_W-1:0] row_number;
  } tag_t;

endpackage

`default_nettype wire

FILE: rtl/tbdsdp_if.sv
`default_nettype none

interface tbdsdp_item_if #(parameter int ACT_BITS = 16);
  import tbdsdp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [BYTE_W-1:0]          weight_codes;
  logic signed [ACT_BITS-1:0] act_zero;
  logic signed [ACT_BITS-1:0] act_one;
  logic signed [ACT_BITS-1:0] act_two;
  logic signed [ACT_BITS-1:0] act_three;
  logic signed [SCALE_W-1:0]  inner_scale;
  logic signed [SCALE_W-1:0]  outer_scale;
  logic                       row_end;

  modport source (output valid, weight_codes, act_zero, act_one, act_two, act_three,
                  inner_scale, outer_scale, row_end, input ready);
  modport sink (input valid, weight_codes, act_zero, act_one, act_two, act_three,
                inner_scale, outer_scale, row_end, output ready);
endinterface

interface tbdsdp_result_if #(parameter int SUM_BITS = 48);
  import tbdsdp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SUM_BITS-1:0] row_sum;
  logic [ROW_W-1:0]           row_number;
  logic                       overflowed;

  modport source (output valid, row_sum, row_number, overflowed, input ready);
  modport sink (input valid, row_sum, row_number, overflowed, output ready);
endinterface

interface tbdsdp_cfg_if;
  import tbdsdp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tbdsdp_front.sv
`default_nettype none

module tbdsdp_front #(
  parameter int ACT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tbdsdp_item_if.sink                         item_i,
  tbdsdp_cfg_if.sink                          cfg_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [tbdsdp_pkg::BYTE_W-1:0]       codes_o,
  output logic signed [ACT_BITS-1:0]          act_o [tbdsdp_pkg::CODES],
  output logic signed [tbdsdp_pkg::SCALE_W-1:0] inner_o,
  output logic signed [tbdsdp_pkg::SCALE_W-1:0] outer_o,
  output tbdsdp_pkg::tag_t                    tag_o
);
  import tbdsdp_pkg::*;

  logic [GLEN_W-1:0] glen_q;
  logic [ROWS_W-1:0] rows_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic signed [SCALE_W-1:0] held_inner_q, held_outer_q;
  logic signed [SCALE_W-1:0] inner_sel, outer_sel;
  logic              valid_q;

  logic [GLEN_W-1:0] glen_rnd, glen_eff;
  logic [GLEN_W-1:0] pos_next;
  logic [ROWS_W-1:0] rows_eff, row_next;
  logic              first, accept;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = !valid_q || ready_i;
  assign accept       = item_i.valid && item_i.ready;

  assign glen_rnd = {glen_q[GLEN_W-1:2], 2'b00};
  assign glen_eff = (glen_rnd < GLEN_MIN) ? GLEN_MIN :
                    (glen_rnd > GLEN_MAX) ? GLEN_MAX : glen_rnd;
  assign pos_next = {1'b0, pos_q} + GLEN_W'(CODES);

  assign rows_eff = (rows_q == '0 || rows_q > ROWS_MAX) ? ROWS_MAX : rows_q;
  assign row_next = {1'b0, row_q} + ROWS_W'(1);

  assign first     = (pos_q == '0);
  assign inner_sel = first ? item_i.inner_scale : held_inner_q;
  assign outer_sel = first ? item_i.outer_scale : held_outer_q;

  always_comb begin
    pos_d = pos_next[POS_W-1:0];
    row_d = row_q;
    if (item_i.row_end || pos_next >= glen_eff) begin
      pos_d = '0;
    end
    if (item_i.row_end) begin
      row_d = (row_next >= rows_eff) ? '0 : row_next[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glen_q <= GLEN_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_i.valid) begin
      unique case (reg_e'(cfg_i.index))
        REG_GROUP_LENGTH: glen_q <= cfg_i.data[GLEN_W-1:0];
        REG_ROWS_IN_USE:  rows_q <= cfg_i.data[ROWS_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      row_q        <= '0;
      held_inner_q <= '0;
      held_outer_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (item_i.ready) begin
        valid_q <= item_i.valid;
      end
      if (accept) begin
        pos_q        <= pos_d;
        row_q        <= row_d;
        held_inner_q <= inner_sel;
        held_outer_q <= outer_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      codes_o          <= item_i.weight_codes;
      act_o[0]         <= item_i.act_zero;
      act_o[1]         <= item_i.act_one;
      act_o[2]         <= item_i.act_two;
      act_o[3]         <= item_i.act_three;
      inner_o          <= inner_sel;
      outer_o          <= outer_sel;
      tag_o.row_end    <= item_i.row_end;
      tag_o.row_number <= row_q;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/tbdsdp_mul.sv
`default_nettype none

module tbdsdp_mul #(
  parameter int ACT_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [tbdsdp_pkg::BYTE_W-1:0]         codes_i,
  input  logic signed [ACT_BITS-1:0]            act_i [tbdsdp_pkg::CODES],
  input  logic signed [tbdsdp_pkg::SCALE_W-1:0] inner_i,
  input  logic signed [tbdsdp_pkg::SCALE_W-1:0] outer_i,
  input  tbdsdp_pkg::tag_t                      tag_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [ACT_BITS+tbdsdp_pkg::WEIGHT_W+1:0] bsum_o,
  output tbdsdp_pkg::tag_t                      tag_o
);
  import tbdsdp_pkg::*;

  localparam int PROD_W = ACT_BITS + WEIGHT_W;
  localparam int BSUM_W = PROD_W + 2;

  logic signed [WEIGHT_W-1:0] weight [CODES];
  logic signed [PROD_W-1:0]   prod_d [CODES];
  logic signed [PROD_W-1:0]   prod_q [CODES];
  logic signed [BSUM_W-1:0]   bsum_d;
  logic                       mul_valid_q, sum_valid_q;
  logic                       mul_ready, sum_ready;
  tag_t                       mul_tag_q;

  assign sum_ready = !sum_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || sum_ready;
  assign ready_o   = mul_ready;

  always_comb begin
    for (int k = 0; k < CODES; k++) begin
      case (code_e'(codes_i[CODE_W*k +: CODE_W]))
        CODE_NEG_OUTER: weight[k] = -WEIGHT_W'(outer_i);
        CODE_NEG_INNER: weight[k] = -WEIGHT_W'(inner_i);
        CODE_POS_INNER: weight[k] = WEIGHT_W'(inner_i);
        default:        weight[k] = WEIGHT_W'(outer_i);
      endcase
      prod_d[k] = PROD_W'(weight[k]) * PROD_W'(act_i[k]);
    end
  end

  always_comb begin
    bsum_d = '0;
    for (int k = 0; k < CODES; k++) begin
      bsum_d = bsum_d + BSUM_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_q <= valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && mul_ready) begin
      prod_q    <= prod_d;
      mul_tag_q <= tag_i;
    end
    if (mul_valid_q && sum_ready) begin
      bsum_o <= bsum_d;
      tag_o  <= mul_tag_q;
    end
  end

  assign valid_o = sum_valid_q;

endmodule

`default_nettype wire

FILE: rtl/tbdsdp_acc.sv
`default_nettype none

module tbdsdp_acc #(
  parameter int ACT_BITS = 16,
  parameter int SUM_BITS = 48
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic signed [ACT_BITS+tbdsdp_pkg::WEIGHT_W+1:0] bsum_i,
  input  tbdsdp_pkg::tag_t                              tag_i,
  tbdsdp_result_if.source                               result_o
);
  import tbdsdp_pkg::*;

  localparam int BSUM_W = ACT_BITS + WEIGHT_W + 2;
  localparam int EXT_W  = ((SUM_BITS > BSUM_W) ? SUM_BITS : BSUM_W) + 1;

  logic signed [SUM_BITS-1:0] sum_q, sum_new;
  logic signed [EXT_W-1:0]    sum_ext;
  logic [EXT_W-SUM_BITS:0]    upper;
  logic                       fits, seen_q, out_valid_q, out_free, go;

  assign out_free = !out_valid_q || result_o.ready;
  assign ready_o  = !tag_i.row_end || out_free;
  assign go       = valid_i && ready_o;

  assign sum_ext = EXT_W'(sum_q) + EXT_W'(bsum_i);
  assign upper   = sum_ext[EXT_W-1:SUM_BITS-1];
  assign fits    = (&upper) || !(|upper);
  assign sum_new = fits ? sum_ext[SUM_BITS-1:0] :
                   sum_ext[EXT_W-1] ? {1'b1, {(SUM_BITS-1){1'b0}}} :
                                      {1'b0, {(SUM_BITS-1){1'b1}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (go && tag_i.row_end) begin
        sum_q       <= '0;
        seen_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (go) begin
          sum_q  <= sum_new;
          seen_q <= seen_q || !fits;
        end
        if (result_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && tag_i.row_end) begin
      result_o.row_sum    <= sum_new;
      result_o.row_number <= tag_i.row_number;
      result_o.overflowed <= seen_q || !fits;
    end
  end

  assign result_o.valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/two_bit_dual_scale_dot_product.sv
// Row dot product of 2-bit dual-scale weights against Q8.8 activations.
// One weight byte (four codes and four activations) is taken per cycle while
// the input side is not stalled, with no gaps between rows or groups. A row's
// Q28.20 sum appears on the result channel after its last byte passes the input
// register, four 17x16 multipliers, a four-way adder, then the saturating
// accumulator with the result register. The only loop is the single wide
// saturating add of the running sum, so sustained rate is one byte per clock
// while not stalled; the input side stalls only when a finished row sum is
// still waiting at the output and the stages behind it are full.
`default_nettype none

module two_bit_dual_scale_dot_product #(
  parameter int ACT_BITS = 16,
  parameter int SUM_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tbdsdp_item_if.sink     item_i,
  tbdsdp_cfg_if.sink      cfg_i,
  tbdsdp_result_if.source result_o
);
  import tbdsdp_pkg::*;

  logic                       f_valid, f_ready;
  logic [BYTE_W-1:0]          f_codes;
  logic signed [ACT_BITS-1:0] f_act [CODES];
  logic signed [SCALE_W-1:0]  f_inner, f_outer;
  tag_t                       f_tag;

  logic                                  m_valid, m_ready;
  logic signed [ACT_BITS+WEIGHT_W+1:0]   m_bsum;
  tag_t                                  m_tag;

  tbdsdp_front #(.ACT_BITS(ACT_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cfg_i   (cfg_i),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .codes_o (f_codes),
    .act_o   (f_act),
    .inner_o (f_inner),
    .outer_o (f_outer),
    .tag_o   (f_tag)
  );

  tbdsdp_mul #(.ACT_BITS(ACT_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .codes_i (f_codes),
    .act_i   (f_act),
    .inner_i (f_inner),
    .outer_i (f_outer),
    .tag_i   (f_tag),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .bsum_o  (m_bsum),
    .tag_o   (m_tag)
  );

  tbdsdp_acc #(.ACT_BITS(ACT_BITS), .SUM_BITS(SUM_BITS)) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m_valid),
    .ready_o  (m_ready),
    .bsum_i   (m_bsum),
    .tag_i    (m_tag),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
